### design/nmea_pkg.sv
`timescale 1ns / 1ps

package nmea_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 128;

  // characters that frame a sentence
  localparam logic [7:0] CHAR_START = 8'h24;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;

  localparam logic [2:0]  TAIL_BYTES     = 3'd4;
  localparam logic [2:0]  TAIL_AT_HIGH   = 3'd3;
  localparam logic [2:0]  TAIL_AT_LOW    = 3'd2;
  localparam logic [15:0] FRAME_TMO_RST  = 16'd100;
  localparam logic [15:0] IFRAME_TMO_RST = 16'd2000;
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

  // request codes
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_OVF     = 2'd1;
  localparam logic [1:0] ERR_CHK     = 2'd2;
  localparam logic [1:0] ERR_TMO     = 2'd3;

  // register indexes
  localparam logic REG_FRAME_TMO  = 1'b0;
  localparam logic REG_IFRAME_TMO = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_TAIL = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  checksum_accum;
    logic [2:0]  tail_left;
    logic [7:0]  hex_high_char;
    logic [7:0]  hex_low_char;
    logic [15:0] elapsed_ms;
    logic        ready_flag;
    logic [15:0] overflow_count;
    logic [15:0] checksum_count;
    logic [15:0] timeout_count;
  } rx_state_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic [6:0]  byte_index;
    logic        frame_ok;
    logic [1:0]  frame_error;
    logic        frame_ready;
    logic        gps_active;
    logic [15:0] overflow_errors;
    logic [15:0] checksum_errors;
    logic [15:0] timeout_errors;
  } rx_result_t;

  // bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

endpackage

### design/nmea_rx_step.sv
`timescale 1ns / 1ps

module nmea_rx_step #(
  parameter int MAX_FRAME_BYTES = nmea_pkg::MAX_FRAME_BYTES_DEF,
  parameter int LEN_W           = $clog2(MAX_FRAME_BYTES)
) (
  input  logic [1:0]            req,
  input  logic [7:0]            rx_byte,
  input  logic [15:0]           frame_tmo,
  input  logic [15:0]           iframe_tmo,
  input  nmea_pkg::rx_state_t   cur,
  input  logic [LEN_W-1:0]      len_cur,
  output nmea_pkg::rx_state_t   nxt,
  output logic [LEN_W-1:0]      len_nxt,
  output nmea_pkg::rx_result_t  res
);
  import nmea_pkg::*;

  logic        room, is_byte, start, in_body, in_tail, tail_take, is_star;
  logic        store, ovf, check, match, chk, tmo, any_err, release_req;
  logic [2:0]  tl_dec, tl_after;
  logic [7:0]  hi_char, lo_char;
  logic [4:0]  hi_nib, lo_nib;
  logic [15:0] el_after;
  phase_t      phase_nxt;

  // event decode
  always_comb begin
    room        = len_cur < LEN_W'(MAX_FRAME_BYTES - 1);
    is_star     = rx_byte == CHAR_STAR;
    release_req = req == REQ_RELEASE;
    is_byte     = (req == REQ_BYTE) && !cur.ready_flag;
    start       = is_byte && (cur.phase == PH_HUNT) && (rx_byte == CHAR_START);
    in_body     = is_byte && (cur.phase == PH_BODY);
    in_tail     = is_byte && (cur.phase == PH_TAIL);
    tail_take   = in_tail && (cur.tail_left != 3'd0);
    tl_dec      = cur.tail_left - 3'd1;
    tl_after    = tail_take ? tl_dec : cur.tail_left;
    store       = start || ((in_body || tail_take) && room);
    ovf         = (in_body || tail_take) && !room;
    hi_char     = (tail_take && tl_dec == TAIL_AT_HIGH) ? rx_byte : cur.hex_high_char;
    lo_char     = (tail_take && tl_dec == TAIL_AT_LOW) ? rx_byte : cur.hex_low_char;
    hi_nib      = hex_nibble(hi_char);
    lo_nib      = hex_nibble(lo_char);
    check       = in_tail && (tl_after == 3'd0) && !ovf;
    match       = check && !hi_nib[4] && !lo_nib[4]
                  && ({hi_nib[3:0], lo_nib[3:0]} == cur.checksum_accum);
    chk         = check && !match;
    if (start) begin
      el_after = '0;
    end else if (req == REQ_TICK && cur.elapsed_ms != ELAPSED_MAX) begin
      el_after = cur.elapsed_ms + 16'd1;
    end else begin
      el_after = cur.elapsed_ms;
    end
    tmo = (el_after >= frame_tmo)
          && ((is_byte && (start || in_body || (in_tail && !match)))
              || (req == REQ_TICK && !cur.ready_flag && cur.phase != PH_HUNT));
    any_err = ovf || chk || tmo;
  end

  // phase next state
  always_comb begin
    phase_nxt = cur.phase;
    if (any_err || release_req || match) begin
      phase_nxt = PH_HUNT;
    end else if (start) begin
      phase_nxt = PH_BODY;
    end else if (in_body && is_star) begin
      phase_nxt = PH_TAIL;
    end
  end

  // datapath state and result
  always_comb begin
    nxt.phase          = phase_nxt;
    nxt.checksum_accum = cur.checksum_accum;
    if (start) begin
      nxt.checksum_accum = '0;
    end else if (in_body && !is_star) begin
      nxt.checksum_accum = cur.checksum_accum ^ rx_byte;
    end
    nxt.tail_left = tl_after;
    if (in_body && is_star) begin
      nxt.tail_left = TAIL_BYTES;
    end
    nxt.hex_high_char = hi_char;
    nxt.hex_low_char  = lo_char;
    nxt.elapsed_ms    = el_after;
    nxt.ready_flag    = cur.ready_flag;
    if (any_err || release_req) begin
      nxt.ready_flag = 1'b0;
    end else if (match) begin
      nxt.ready_flag = 1'b1;
    end
    nxt.overflow_count = cur.overflow_count + {15'd0, ovf};
    nxt.checksum_count = cur.checksum_count + {15'd0, chk};
    nxt.timeout_count  = cur.timeout_count + {15'd0, tmo};

    len_nxt = len_cur;
    if (start) begin
      len_nxt = LEN_W'(1);
    end else if (store) begin
      len_nxt = len_cur + LEN_W'(1);
    end

    res.byte_valid = store;
    res.byte_value = store ? rx_byte : 8'd0;
    res.byte_index = (store && !start) ? 7'(len_cur) : 7'd0;
    res.frame_ok   = match;
    if (ovf) begin
      res.frame_error = ERR_OVF;
    end else if (chk) begin
      res.frame_error = ERR_CHK;
    end else if (tmo) begin
      res.frame_error = ERR_TMO;
    end else begin
      res.frame_error = ERR_NONE;
    end
    res.frame_ready     = nxt.ready_flag;
    res.gps_active      = el_after < iframe_tmo;
    res.overflow_errors = nxt.overflow_count;
    res.checksum_errors = nxt.checksum_count;
    res.timeout_errors  = nxt.timeout_count;
  end

endmodule

### design/nmea_sentence_receiver.sv
`timescale 1ns / 1ps
// nmea 0183 sentence receiver with checksum check
//
// in channel: one item per request. in_tuser carries the request kind
// (received byte, millisecond tick, release of a held frame) and in_tdata
// the received character. out channel: exactly one result item per input
// item, in order, carrying the echoed frame byte with its index, the
// frame verdict, the ready flag, gps activity and the three error counters.
// cfg port: apb-style, frame timeout at 0x0, interframe timeout at 0x4.
//
// an item is held in the input register, and the whole update runs in
// one combinational pass from there into the result register, which
// offers the result. one item per cycle is sustained while out_tready
// stays high. in_tready follows out_tready through the result register:
// a stalled receiver holds the result, the input register takes one more
// item, and in_tready then stays low until the result leaves.
// reset clears the frame state (hunting for '$', elapsed time saturated,
// counters zero) and loads the timeout registers with 100 and 2000 ms.
module nmea_sentence_receiver #(
  parameter int MAX_FRAME_BYTES = nmea_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic [1:0]  in_tuser,   // req_type
  // out channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // byte_value, byte_index, frame_ok, frame_error, frame_ready, gps_active,
  // overflow_errors, checksum_errors, timeout_errors, zero pad
  output logic [71:0] out_tdata,
  output logic [0:0]  out_tuser,  // byte_valid
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import nmea_pkg::*;

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES);

  // configuration registers
  logic [15:0] frame_tmo_r, iframe_tmo_r;
  logic        cfg_wr;

  // input register
  logic        s_v_r;
  logic [1:0]  s_req_r;
  logic [7:0]  s_byte_r;

  // frame state
  rx_state_t   st_r, st_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  // result register
  logic        out_v_r;
  rx_result_t  res_nxt, res_r;

  logic        adv;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_IFRAME_TMO) ? {16'd0, iframe_tmo_r}
                                                       : {16'd0, frame_tmo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_tmo_r  <= FRAME_TMO_RST;
      iframe_tmo_r <= IFRAME_TMO_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_IFRAME_TMO) begin
        iframe_tmo_r <= cfg_pwdata[15:0];
      end else begin
        frame_tmo_r <= cfg_pwdata[15:0];
      end
    end
  end

  // the result register moves when it is empty or being taken
  assign adv       = !out_v_r || out_tready;
  assign in_tready = !s_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s_v_r <= 1'b1;
    end else if (adv) begin
      s_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_req_r  <= in_tuser;
      s_byte_r <= in_tdata;
    end
  end

  nmea_rx_step #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .LEN_W           (LEN_W)
  ) u_step (
    .req        (s_req_r),
    .rx_byte    (s_byte_r),
    .frame_tmo  (frame_tmo_r),
    .iframe_tmo (iframe_tmo_r),
    .cur        (st_r),
    .len_cur    (len_r),
    .nxt        (st_nxt),
    .len_nxt    (len_nxt),
    .res        (res_nxt)
  );

  // frame state updates once per item, as the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase          <= PH_HUNT;
      st_r.checksum_accum <= '0;
      st_r.tail_left      <= '0;
      st_r.hex_high_char  <= '0;
      st_r.hex_low_char   <= '0;
      st_r.elapsed_ms     <= ELAPSED_MAX;
      st_r.ready_flag     <= 1'b0;
      st_r.overflow_count <= '0;
      st_r.checksum_count <= '0;
      st_r.timeout_count  <= '0;
      len_r               <= '0;
    end else if (s_v_r && adv) begin
      st_r  <= st_nxt;
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_v_r && adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tuser[0] = res_r.byte_valid;
  assign out_tdata    = {4'd0,
                         res_r.timeout_errors,
                         res_r.checksum_errors,
                         res_r.overflow_errors,
                         res_r.gps_active,
                         res_r.frame_ready,
                         res_r.frame_error,
                         res_r.frame_ok,
                         res_r.byte_index,
                         res_r.byte_value};

  // a held frame always leaves the receiver hunting
  a_ready_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.ready_flag |-> st_r.phase == PH_HUNT)
    else $error("ready flag set outside hunting phase");

  // the tail phase never sits with no tail bytes left
  a_tail_left: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_TAIL |-> st_r.tail_left != 3'd0)
    else $error("tail phase with no tail bytes left");

  // a good frame is reported as held and free of errors
  a_ok_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.frame_ok |-> res_r.frame_ready && res_r.frame_error == ERR_NONE)
    else $error("frame ok without ready or with an error");

endmodule
